// ===== hw/rtl/cpulsb_pkg.sv =====
// Shared types and constants of the logic, rotate, shift and bit unit.
package cpulsb_pkg;

   typedef enum logic [4:0] {
      MODE_XOR  = 5'd0,
      MODE_OR   = 5'd1,
      MODE_AND  = 5'd2,
      MODE_SWAP = 5'd3,
      MODE_RLA  = 5'd4,
      MODE_RLCA = 5'd5,
      MODE_RRA  = 5'd6,
      MODE_RRCA = 5'd7,
      MODE_CPL  = 5'd8,
      MODE_CCF  = 5'd9,
      MODE_SCF  = 5'd10,
      MODE_BIT  = 5'd11,
      MODE_RL   = 5'd12,
      MODE_RLC  = 5'd13,
      MODE_RR   = 5'd14,
      MODE_RRC  = 5'd15,
      MODE_SRL  = 5'd16,
      MODE_SRA  = 5'd17,
      MODE_SLA  = 5'd18,
      MODE_RES  = 5'd19,
      MODE_SET  = 5'd20,
      MODE_DAA  = 5'd21
   } mode_type;

   localparam logic [7:0] DAA_HI_ADJ   = 8'h60;
   localparam logic [7:0] DAA_HI_LIMIT = 8'h99;
   localparam logic [3:0] DAA_LO_LIMIT = 4'h9;
   localparam logic [7:0] DAA_LO_ADJ   = 8'h06;

   typedef struct packed {
      mode_type   mode;
      logic [7:0] acc_in;
      logic [7:0] operand_in;
      logic [2:0] bit_index;
      logic       z_in;
      logic       n_in;
      logic       h_in;
      logic       c_in;
   } req_type;

   typedef struct packed {
      logic [7:0] result;
      logic       write_back;
      logic       z_out;
      logic       n_out;
      logic       h_out;
      logic       c_out;
   } rsp_type;

endpackage

// ===== hw/rtl/cpulsb_req_if.sv =====
// Request channel interface: operation and operands with valid/ready handshake.
interface cpulsb_req_if;
   logic                 valid;
   logic                 ready;
   cpulsb_pkg::mode_type mode;
   logic [7:0]           acc_in;
   logic [7:0]           operand_in;
   logic [2:0]           bit_index;
   logic                 z_in;
   logic                 n_in;
   logic                 h_in;
   logic                 c_in;

   modport source (output valid, mode, acc_in, operand_in, bit_index,
                   z_in, n_in, h_in, c_in, input ready);
   modport sink (input valid, mode, acc_in, operand_in, bit_index,
                 z_in, n_in, h_in, c_in, output ready);
endinterface

// ===== hw/rtl/cpulsb_rsp_if.sv =====
// Response channel interface: result byte, write-back strobe and flags.
interface cpulsb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] result;
   logic       write_back;
   logic       z_out;
   logic       n_out;
   logic       h_out;
   logic       c_out;

   modport source (output valid, result, write_back, z_out, n_out, h_out, c_out,
                   input ready);
   modport sink (input valid, result, write_back, z_out, n_out, h_out, c_out,
                 output ready);
endinterface

// ===== hw/rtl/cpu_logic_shift_bit_unit_core.sv =====
// Top level of the SM83-style logic, rotate, shift and bit unit.
//
// Usage: the request channel (req_ch) carries one operation per transaction:
// the operation code, accumulator, operand byte, bit index and the incoming
// Z N H C flags. The response channel (rsp_ch) returns one transaction per
// request with the new byte, the write-back strobe and the new flags, in
// request order.
// Pipeline: a request accepted into the input register passes through one
// level of byte-wide logic and lands in the output register, which drives
// rsp_ch; a stall on rsp_ch can hold it in the input register.
// Throughput: one transaction per cycle while rsp_ch.ready is high, since
// each register moves whenever the one after it is empty or being emptied.
// Stalls: when rsp_ch.ready is low the output register holds its result, the
// input register fills, and req_ch.ready then drops until space frees up.
// Reset: synchronous reset empties both registers and drops any transaction
// in flight; no state survives between transactions.
// Unused operation codes pass the accumulator and flags through, no write.
module cpu_logic_shift_bit_unit_core (
   input logic clock,
   input logic reset,
   cpulsb_req_if.sink   req_ch,
   cpulsb_rsp_if.source rsp_ch
);
   import cpulsb_pkg::*;

   logic    s1_valid_ff, s1_valid_in;
   req_type s1_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff;
   rsp_type rsp_in;
   logic    out_free;
   logic    in_take;

   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = !s1_valid_ff || out_free;
   assign in_take      = req_ch.valid && req_ch.ready;

   assign s1_valid_in  = req_ch.ready ? req_ch.valid : s1_valid_ff;
   assign rsp_valid_in = out_free ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         s1_ff.mode       <= req_ch.mode;
         s1_ff.acc_in     <= req_ch.acc_in;
         s1_ff.operand_in <= req_ch.operand_in;
         s1_ff.bit_index  <= req_ch.bit_index;
         s1_ff.z_in       <= req_ch.z_in;
         s1_ff.n_in       <= req_ch.n_in;
         s1_ff.h_in       <= req_ch.h_in;
         s1_ff.c_in       <= req_ch.c_in;
      end
      if (out_free && s1_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   // Execute stage.
   logic [7:0] a, v, r, mask, daa_r;
   logic       c, co, daa_c;

   assign a    = s1_ff.acc_in;
   assign v    = s1_ff.operand_in;
   assign c    = s1_ff.c_in;
   assign mask = 8'd1 << s1_ff.bit_index;

   // Decimal adjust: the low-nibble test follows the high adjustment, which
   // leaves the low nibble untouched.
   always_comb begin
      daa_r = a;
      daa_c = c;
      if (!s1_ff.n_in) begin
         if (c || (a > DAA_HI_LIMIT)) begin
            daa_r = a + DAA_HI_ADJ;
            daa_c = 1'b1;
         end
         if (s1_ff.h_in || (a[3:0] > DAA_LO_LIMIT)) begin
            daa_r = daa_r + DAA_LO_ADJ;
         end
      end else begin
         if (c) begin
            daa_r = daa_r - DAA_HI_ADJ;
         end
         if (s1_ff.h_in) begin
            daa_r = daa_r - DAA_LO_ADJ;
         end
      end
   end

   always_comb begin
      r  = 8'd0;
      co = 1'b0;
      rsp_in.result     = a;
      rsp_in.write_back = 1'b1;
      rsp_in.z_out      = s1_ff.z_in;
      rsp_in.n_out      = 1'b0;
      rsp_in.h_out      = 1'b0;
      rsp_in.c_out      = c;
      case (s1_ff.mode)
         MODE_XOR, MODE_OR, MODE_AND, MODE_SWAP, MODE_RL, MODE_RLC, MODE_RR,
         MODE_RRC, MODE_SRL, MODE_SRA, MODE_SLA: begin
            case (s1_ff.mode)
               MODE_XOR:  r = a ^ v;
               MODE_OR:   r = a | v;
               MODE_AND:  r = a & v;
               MODE_SWAP: r = {v[3:0], v[7:4]};
               MODE_RL:   begin r = {v[6:0], c};    co = v[7]; end
               MODE_RLC:  begin r = {v[6:0], v[7]}; co = v[7]; end
               MODE_RR:   begin r = {c, v[7:1]};    co = v[0]; end
               MODE_RRC:  begin r = {v[0], v[7:1]}; co = v[0]; end
               MODE_SRL:  begin r = {1'b0, v[7:1]}; co = v[0]; end
               MODE_SRA:  begin r = {v[7], v[7:1]}; co = v[0]; end
               MODE_SLA:  begin r = {v[6:0], 1'b0}; co = v[7]; end
               default:   r = 8'd0;
            endcase
            rsp_in.result = r;
            rsp_in.z_out  = (r == 8'd0);
            rsp_in.h_out  = (s1_ff.mode == MODE_AND);
            rsp_in.c_out  = co;
         end
         MODE_RLA, MODE_RLCA, MODE_RRA, MODE_RRCA: begin
            case (s1_ff.mode)
               MODE_RLA:  begin r = {a[6:0], c};    co = a[7]; end
               MODE_RLCA: begin r = {a[6:0], a[7]}; co = a[7]; end
               MODE_RRA:  begin r = {c, a[7:1]};    co = a[0]; end
               default:   begin r = {a[0], a[7:1]}; co = a[0]; end
            endcase
            rsp_in.result = r;
            rsp_in.z_out  = 1'b0;
            rsp_in.c_out  = co;
         end
         MODE_CPL: begin
            rsp_in.result = ~a;
            rsp_in.n_out  = 1'b1;
            rsp_in.h_out  = 1'b1;
         end
         MODE_CCF: begin
            rsp_in.write_back = 1'b0;
            rsp_in.c_out      = ~c;
         end
         MODE_SCF: begin
            rsp_in.write_back = 1'b0;
            rsp_in.c_out      = 1'b1;
         end
         MODE_BIT: begin
            rsp_in.result     = v;
            rsp_in.write_back = 1'b0;
            rsp_in.z_out      = ~|(v & mask);
            rsp_in.h_out      = 1'b1;
         end
         MODE_RES, MODE_SET: begin
            rsp_in.result = (s1_ff.mode == MODE_SET) ? (v | mask) : (v & ~mask);
            rsp_in.n_out  = s1_ff.n_in;
            rsp_in.h_out  = s1_ff.h_in;
         end
         MODE_DAA: begin
            rsp_in.result = daa_r;
            rsp_in.z_out  = (daa_r == 8'd0);
            rsp_in.n_out  = s1_ff.n_in;
            rsp_in.c_out  = daa_c;
         end
         default: begin
            rsp_in.write_back = 1'b0;
            rsp_in.n_out      = s1_ff.n_in;
            rsp_in.h_out      = s1_ff.h_in;
         end
      endcase
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.result     = rsp_ff.result;
   assign rsp_ch.write_back = rsp_ff.write_back;
   assign rsp_ch.z_out      = rsp_ff.z_out;
   assign rsp_ch.n_out      = rsp_ff.n_out;
   assign rsp_ch.h_out      = rsp_ff.h_out;
   assign rsp_ch.c_out      = rsp_ff.c_out;

endmodule
